/* hw/rtl/lens_distort_project_unit_assert.svh */
// ---------------------------------------------------------------------------
// lens_distort_project_unit assertion macros
// shared property forms; the including module supplies clk and arst_n
// ---------------------------------------------------------------------------
`ifndef LENS_DISTORT_PROJECT_UNIT_ASSERT_SVH
`define LENS_DISTORT_PROJECT_UNIT_ASSERT_SVH

// same-cycle implication
`define LDP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LDP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/ldp_pkg.sv */
// ---------------------------------------------------------------------------
// ldp_pkg
// types, constants and fixed-point helpers for the lens projection pipeline
// ---------------------------------------------------------------------------
package ldp_pkg;

	// internal value: signed Q.28, magnitude kept below 2^35
	typedef logic signed [35:0] q_t;

	localparam q_t LIM_Q = 36'sh7_FFFF_FFFF;
	localparam q_t ONE_Q = 36'sh0_1000_0000;
	localparam logic [69:0] LIM_Q_MAG = 70'h7_FFFF_FFFF;
	localparam logic [69:0] LIM_OUT_MAG = 70'h100_0000_0000;

	// quotient width and divider pipeline shape
	localparam int Q_W = 36;
	localparam int DIV_BITS = 2;
	localparam int DIV_STAGES = Q_W / DIV_BITS;

	// configuration port
	localparam int PADDR_W = 6;

	typedef enum logic [2:0] {
		REG_FOCAL = 3'd0,
		REG_PP    = 3'd1,
		REG_TAN   = 3'd2,
		REG_KNUM  = 3'd3,
		REG_KMIX  = 3'd4,
		REG_KDEN  = 3'd5
	} reg_idx_t;

	localparam logic [63:0] FOCAL_RST = 64'h0001_0000_0001_0000;

	typedef struct packed {
		q_t   v;
		logic sat;
	} qres_t;

	typedef struct packed {
		logic signed [41:0] v;
		logic               sat;
	} ores_t;

	// per-word side data that rides along the divider
	typedef struct packed {
		q_t   x;
		q_t   y;
		q_t   t2x;
		q_t   ptx;
		q_t   pty;
		q_t   t2y;
		logic neg;
		logic bad;
		logic ovf;
		logic sat;
	} side_t;

	// product shifted back toward zero and clipped to the internal bound
	function automatic qres_t mulq(input q_t a, input q_t b, input logic sh24);
		logic [34:0] ua;
		logic [34:0] ub;
		logic [69:0] p;
		logic [69:0] r;
		logic [34:0] mag;
		qres_t       res;
		ua = 35'(a[35] ? -a : a);
		ub = 35'(b[35] ? -b : b);
		p = 70'(ua) * 70'(ub);
		r = sh24 ? (p >> 24) : (p >> 28);
		res.sat = (r > LIM_Q_MAG);
		mag = res.sat ? LIM_Q[34:0] : r[34:0];
		res.v = (a[35] ^ b[35]) ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		return res;
	endfunction

	// focal scaling into Q16.16, clipped to +-2^40
	function automatic ores_t mulo(input logic [31:0] f, input q_t b);
		logic [34:0] ub;
		logic [69:0] p;
		logic [69:0] r;
		logic [40:0] mag;
		ores_t       res;
		ub = 35'(b[35] ? -b : b);
		p = 70'(f) * 70'(ub);
		r = p >> 28;
		res.sat = (r > LIM_OUT_MAG);
		mag = res.sat ? LIM_OUT_MAG[40:0] : r[40:0];
		res.v = b[35] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		return res;
	endfunction

	// sum clipped to the internal bound
	function automatic qres_t addq(input q_t a, input q_t b);
		logic signed [36:0] s;
		qres_t              res;
		s = 37'(a) + 37'(b);
		res.sat = 1'b0;
		res.v = 36'(s);
		if (s > 37'(LIM_Q)) begin
			res.sat = 1'b1;
			res.v = LIM_Q;
		end else if (s < -37'(LIM_Q)) begin
			res.sat = 1'b1;
			res.v = -LIM_Q;
		end
		return res;
	endfunction

endpackage

/* hw/rtl/ldp_div.sv */
// ---------------------------------------------------------------------------
// ldp_div
// pipelined restoring divider, two quotient bits a stage, (un << 28) / ud
// ---------------------------------------------------------------------------
module ldp_div
	import ldp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [34:0] in_un,
	input  logic [34:0] in_ud,
	input  side_t       in_side,
	output logic        out_vld,
	output logic [35:0] out_q,
	output side_t       out_side
);

`include "lens_distort_project_unit_assert.svh"

	typedef struct packed {
		logic [34:0] rem;
		logic [35:0] low;
		logic [35:0] quo;
	} dst_t;

	// two restoring steps
	function automatic dst_t dstep(input dst_t s, input logic [34:0] d);
		dst_t        o;
		logic [35:0] t;
		o = s;
		for (int j = 0; j < DIV_BITS; j++) begin
			t = {o.rem, o.low[35]};
			o.low = {o.low[34:0], 1'b0};
			if (t >= {1'b0, d}) begin
				o.rem = 35'(t - {1'b0, d});
				o.quo = {o.quo[34:0], 1'b1};
			end else begin
				o.rem = t[34:0];
				o.quo = {o.quo[34:0], 1'b0};
			end
		end
		return o;
	endfunction

	logic [DIV_STAGES-1:0] v_s;
	dst_t                  st_s  [DIV_STAGES];
	logic [34:0]           den_s [DIV_STAGES];
	side_t                 side_s[DIV_STAGES];
	dst_t                  nx    [DIV_STAGES];
	dst_t                  init;

	// top dividend bits go straight into the remainder
	always_comb begin
		init.rem = {8'd0, in_un[34:8]};
		init.low = {in_un[7:0], 28'd0};
		init.quo = '0;
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				nx[k] = dstep(init, in_ud);
			end else begin
				nx[k] = dstep(st_s[k-1], den_s[k-1]);
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (en) begin
			v_s <= {v_s[DIV_STAGES-2:0], in_vld};
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < DIV_STAGES; k++) begin
				st_s[k] <= nx[k];
				if (k == 0) begin
					den_s[k] <= in_ud;
					side_s[k] <= in_side;
				end else begin
					den_s[k] <= den_s[k-1];
					side_s[k] <= side_s[k-1];
				end
			end
		end
	end

	assign out_vld = v_s[DIV_STAGES-1];
	assign out_q = st_s[DIV_STAGES-1].quo;
	assign out_side = side_s[DIV_STAGES-1];

	// checks
	`LDP_ASSERT_IMP(a_div_rem, out_vld && !out_side.bad && !out_side.ovf,
		st_s[DIV_STAGES-1].rem < den_s[DIV_STAGES-1], "divider remainder not below divisor")
	`LDP_ASSERT_NXT(a_div_hold, !en, $stable(v_s), "divider moved while stalled")
	`LDP_ASSERT_NXT(a_div_enter, en && in_vld, v_s[0], "word lost entering the divider")

endmodule

/* hw/rtl/lens_distort_project_unit.sv */
// ---------------------------------------------------------------------------
// lens_distort_project_unit
// rational radial plus tangential lens projection; when not stalled, one point per clock
// ---------------------------------------------------------------------------
// Takes a normalised point (x_norm, y_norm, Q4.28) and returns its pixel
// position (u_pixel, v_pixel, Q16.16) with saturation and bad-denominator
// flags. It accepts one word every clock unless the output stalls, which
// freezes the whole pipeline. It has six stages of squares, powers of R
// and polynomial terms, an eighteen-stage divider producing two quotient
// bits a stage, and five stages of tangential terms, focal scaling and
// output clipping. Coefficients are to be set through the APB port (six
// 64-bit registers at byte address 8*i) while idle; this is not enforced.
module lens_distort_project_unit
	import ldp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// input words
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] x_norm,
	input  logic signed [31:0] y_norm,
	// result words
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] u_pixel,
	output logic signed [31:0] v_pixel,
	output logic               saturated,
	output logic               bad_denominator,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);

`include "lens_distort_project_unit_assert.svh"

	// configuration registers
	logic [63:0] focal_q, pp_q, tan_q, knum_q, kmix_q, kden_q;
	reg_idx_t    cfg_idx;

	assign cfg_idx = reg_idx_t'(paddr[5:3]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_q <= FOCAL_RST;
			pp_q <= '0;
			tan_q <= '0;
			knum_q <= '0;
			kmix_q <= '0;
			kden_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (cfg_idx)
				REG_FOCAL: focal_q <= pwdata;
				REG_PP:    pp_q <= pwdata;
				REG_TAN:   tan_q <= pwdata;
				REG_KNUM:  knum_q <= pwdata;
				REG_KMIX:  kmix_q <= pwdata;
				REG_KDEN:  kden_q <= pwdata;
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_FOCAL: prdata = focal_q;
			REG_PP:    prdata = pp_q;
			REG_TAN:   prdata = tan_q;
			REG_KNUM:  prdata = knum_q;
			REG_KMIX:  prdata = kmix_q;
			REG_KDEN:  prdata = kden_q;
			default:   prdata = '0;
		endcase
	end

	// coefficient fields
	q_t p1, p2, k1, k2, k3, k4, k5, k6;
	assign p1 = 36'($signed(tan_q[63:32]));
	assign p2 = 36'($signed(tan_q[31:0]));
	assign k1 = 36'($signed(knum_q[63:32]));
	assign k2 = 36'($signed(knum_q[31:0]));
	assign k3 = 36'($signed(kmix_q[63:32]));
	assign k4 = 36'($signed(kmix_q[31:0]));
	assign k5 = 36'($signed(kden_q[63:32]));
	assign k6 = 36'($signed(kden_q[31:0]));

	// pipeline advance
	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;
	logic div_vld;

	assign adv = !v_s11 || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6} <= '0;
			{v_s7, v_s8, v_s9, v_s10, v_s11} <= '0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= div_vld;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// stage 1: squares and cross product
	q_t   x_s1, y_s1, x2_s1, y2_s1, xy_s1;
	logic sat_s1;
	qres_t m1x, m1y, m1xy;
	assign m1x = mulq(36'(x_norm), 36'(x_norm), 1'b0);
	assign m1y = mulq(36'(y_norm), 36'(y_norm), 1'b0);
	assign m1xy = mulq(36'(x_norm), 36'(y_norm), 1'b0);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= 36'(x_norm);
			y_s1 <= 36'(y_norm);
			x2_s1 <= m1x.v;
			y2_s1 <= m1y.v;
			xy_s1 <= m1xy.v;
			sat_s1 <= m1x.sat | m1y.sat | m1xy.sat;
		end
	end

	// stage 2: radius squared and doubled squares
	q_t   x_s2, y_s2, xy_s2, r1_s2, x2d_s2, y2d_s2;
	logic sat_s2;
	qres_t a2r, a2x, a2y;
	assign a2r = addq(x2_s1, y2_s1);
	assign a2x = addq(x2_s1, x2_s1);
	assign a2y = addq(y2_s1, y2_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s2 <= x_s1;
			y_s2 <= y_s1;
			xy_s2 <= xy_s1;
			r1_s2 <= a2r.v;
			x2d_s2 <= a2x.v;
			y2d_s2 <= a2y.v;
			sat_s2 <= sat_s1 | a2r.sat | a2x.sat | a2y.sat;
		end
	end

	// stage 3: R^2, tangential sums and p*xy
	q_t   x_s3, y_s3, r1_s3, r2_s3, tx_s3, ty_s3, pxy1_s3, pxy2_s3;
	logic sat_s3;
	qres_t m3r, a3x, a3y, m3p1, m3p2;
	assign m3r = mulq(r1_s2, r1_s2, 1'b0);
	assign a3x = addq(r1_s2, x2d_s2);
	assign a3y = addq(r1_s2, y2d_s2);
	assign m3p1 = mulq(p1, xy_s2, 1'b0);
	assign m3p2 = mulq(p2, xy_s2, 1'b0);

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s3 <= x_s2;
			y_s3 <= y_s2;
			r1_s3 <= r1_s2;
			r2_s3 <= m3r.v;
			tx_s3 <= a3x.v;
			ty_s3 <= a3y.v;
			pxy1_s3 <= m3p1.v;
			pxy2_s3 <= m3p2.v;
			sat_s3 <= sat_s2 | m3r.sat | a3x.sat | a3y.sat | m3p1.sat | m3p2.sat;
		end
	end

	// stage 4: R^3, first polynomial terms, tangential products
	q_t    r3_s4, a1_s4, a2_s4, b1_s4, b2_s4;
	side_t sd_s4;
	qres_t m4r, m4a1, m4a2, m4b1, m4b2, m4tx, m4ty, a4x, a4y;
	assign m4r = mulq(r2_s3, r1_s3, 1'b0);
	assign m4a1 = mulq(k1, r1_s3, 1'b1);
	assign m4a2 = mulq(k2, r2_s3, 1'b1);
	assign m4b1 = mulq(k4, r1_s3, 1'b1);
	assign m4b2 = mulq(k5, r2_s3, 1'b1);
	assign m4tx = mulq(p2, tx_s3, 1'b0);
	assign m4ty = mulq(p1, ty_s3, 1'b0);
	assign a4x = addq(pxy1_s3, pxy1_s3);
	assign a4y = addq(pxy2_s3, pxy2_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			r3_s4 <= m4r.v;
			a1_s4 <= m4a1.v;
			a2_s4 <= m4a2.v;
			b1_s4 <= m4b1.v;
			b2_s4 <= m4b2.v;
			sd_s4.x <= x_s3;
			sd_s4.y <= y_s3;
			sd_s4.t2x <= a4x.v;
			sd_s4.ptx <= m4tx.v;
			sd_s4.pty <= m4ty.v;
			sd_s4.t2y <= a4y.v;
			sd_s4.neg <= 1'b0;
			sd_s4.bad <= 1'b0;
			sd_s4.ovf <= 1'b0;
			sd_s4.sat <= sat_s3 | m4r.sat | m4a1.sat | m4a2.sat | m4b1.sat | m4b2.sat
				| m4tx.sat | m4ty.sat | a4x.sat | a4y.sat;
		end
	end

	// stage 5: cubic terms and partial sums
	q_t    n12_s5, d12_s5, a3_s5, b3_s5;
	side_t sd_s5;
	side_t sd5_n;
	qres_t m5a, m5b, n1, n2, d1, d2;
	assign m5a = mulq(k3, r3_s4, 1'b1);
	assign m5b = mulq(k6, r3_s4, 1'b1);
	assign n1 = addq(ONE_Q, a1_s4);
	assign n2 = addq(n1.v, a2_s4);
	assign d1 = addq(ONE_Q, b1_s4);
	assign d2 = addq(d1.v, b2_s4);

	always_comb begin
		sd5_n = sd_s4;
		sd5_n.sat = sd_s4.sat | m5a.sat | m5b.sat | n1.sat | n2.sat | d1.sat | d2.sat;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n12_s5 <= n2.v;
			d12_s5 <= d2.v;
			a3_s5 <= m5a.v;
			b3_s5 <= m5b.v;
			sd_s5 <= sd5_n;
		end
	end

	// stage 6: numerator, denominator, divider operands
	logic [34:0] un_s6, ud_s6;
	side_t       sd_s6;
	side_t       sd6_n;
	qres_t       nf, df;
	logic [34:0] un6, ud6;
	assign nf = addq(n12_s5, a3_s5);
	assign df = addq(d12_s5, b3_s5);
	assign un6 = 35'(nf.v[35] ? -nf.v : nf.v);
	assign ud6 = 35'(df.v[35] ? -df.v : df.v);

	always_comb begin
		sd6_n = sd_s5;
		sd6_n.neg = nf.v[35] ^ df.v[35];
		sd6_n.bad = (ud6 < 35'h1000);
		sd6_n.ovf = ({8'd0, un6} >= {ud6, 8'd0});
		sd6_n.sat = sd_s5.sat | nf.sat | df.sat;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			un_s6 <= un6;
			ud_s6 <= ud6;
			sd_s6 <= sd6_n;
		end
	end

	// radial factor division
	logic [35:0] div_q;
	side_t       div_sd;

	ldp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_vld   (v_s6),
		.in_un    (un_s6),
		.in_ud    (ud_s6),
		.in_side  (sd_s6),
		.out_vld  (div_vld),
		.out_q    (div_q),
		.out_side (div_sd)
	);

	// stage 7: clip and sign the radial factor
	q_t    fr_s7;
	side_t sd_s7;
	side_t sd7_n;
	logic        qclip;
	logic [34:0] qmag;
	assign qclip = !div_sd.bad && (div_sd.ovf || div_q[35]);
	assign qmag = qclip ? LIM_Q[34:0] : div_q[34:0];

	always_comb begin
		sd7_n = div_sd;
		sd7_n.sat = div_sd.sat | qclip;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (div_sd.bad) begin
				fr_s7 <= '0;
			end else begin
				fr_s7 <= div_sd.neg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
			end
			sd_s7 <= sd7_n;
		end
	end

	// stage 8: radial part of the distorted point
	q_t    xp0_s8, yp0_s8;
	side_t sd_s8;
	side_t sd8_n;
	qres_t m8x, m8y;
	assign m8x = mulq(sd_s7.x, fr_s7, 1'b0);
	assign m8y = mulq(sd_s7.y, fr_s7, 1'b0);

	always_comb begin
		sd8_n = sd_s7;
		sd8_n.sat = sd_s7.sat | m8x.sat | m8y.sat;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xp0_s8 <= m8x.v;
			yp0_s8 <= m8y.v;
			sd_s8 <= sd8_n;
		end
	end

	// stage 9: add tangential terms
	q_t    xp_s9, yp_s9;
	side_t sd_s9;
	side_t sd9_n;
	qres_t ax1, ax2, ay1, ay2;
	assign ax1 = addq(xp0_s8, sd_s8.t2x);
	assign ax2 = addq(ax1.v, sd_s8.ptx);
	assign ay1 = addq(yp0_s8, sd_s8.pty);
	assign ay2 = addq(ay1.v, sd_s8.t2y);

	always_comb begin
		sd9_n = sd_s8;
		sd9_n.sat = sd_s8.sat | ax1.sat | ax2.sat | ay1.sat | ay2.sat;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xp_s9 <= ax2.v;
			yp_s9 <= ay2.v;
			sd_s9 <= sd9_n;
		end
	end

	// stage 10: focal scaling
	logic signed [41:0] uo_s10, vo_s10;
	logic               sat_s10, bad_s10;
	ores_t              mu, mv;
	assign mu = mulo(focal_q[63:32], xp_s9);
	assign mv = mulo(focal_q[31:0], yp_s9);

	always_ff @(posedge clk) begin
		if (adv) begin
			uo_s10 <= mu.v;
			vo_s10 <= mv.v;
			bad_s10 <= sd_s9.bad;
			sat_s10 <= sd_s9.sat | mu.sat | mv.sat;
		end
	end

	// stage 11: principal point and output clip (output register)
	logic signed [42:0] us, vs;
	logic               uhi, ulo, vhi, vlo;
	logic signed [31:0] u_s11, v_s11_d;
	logic               sat_s11, bad_s11;
	assign us = 43'(uo_s10) + 43'($signed(pp_q[63:32]));
	assign vs = 43'(vo_s10) + 43'($signed(pp_q[31:0]));
	assign uhi = us > 43'sd2147483647;
	assign ulo = us < -43'sd2147483648;
	assign vhi = vs > 43'sd2147483647;
	assign vlo = vs < -43'sd2147483648;

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s11 <= uhi ? 32'sh7FFF_FFFF : (ulo ? 32'sh8000_0000 : 32'(us));
			v_s11_d <= vhi ? 32'sh7FFF_FFFF : (vlo ? 32'sh8000_0000 : 32'(vs));
			sat_s11 <= sat_s10 | uhi | ulo | vhi | vlo;
			bad_s11 <= bad_s10;
		end
	end

	assign out_valid = v_s11;
	assign u_pixel = u_s11;
	assign v_pixel = v_s11_d;
	assign saturated = sat_s11;
	assign bad_denominator = bad_s11;

	// checks
	`LDP_ASSERT_NXT(a_take, in_valid && in_ready, v_s1, "accepted word lost at entry")
	`LDP_ASSERT_IMP(a_out_src, $rose(out_valid), $past(v_s10), "result without a source word")
	`LDP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(u_pixel),
		"result word dropped or changed while waiting")

endmodule
